### src/alle_pkg.sv
// Package for the array linked list engine: sizes, status and mode codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package alle_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int SLOT_W = 4;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(DEPTH);

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic app_do;
    logic link;
    logic srch_step;
    logic pred_step;
    logic unlink;
    logic emit_full;
    logic emit_miss;
    logic emit_empty;
    logic rd_step;
  } cmd_t;

  typedef struct packed {
    logic fcount_empty;
    logic tail_null;
    logic head_null;
    logic scan_last;
    logic found_any;
    logic rd_end;
    logic out_free;
  } sts_t;

endpackage

### src/array_linked_list_engine_unit.sv
// Array linked list engine, top level: controller plus datapath.
// Depends on alle_pkg, alle_ctrl and alle_dp.
//
// Holds a singly linked list in 16 slots with a free-slot stack. One word is
// taken at a time. Append writes a slot and, behind an existing tail, links it
// in a further step; a full append or an empty read only emits a status word,
// and an unused mode is dropped. Delete makes a value-match pass over the slot
// stores, one slot per cycle, and on a hit a predecessor pass, then unlinks the
// slot. Read emits one word per element.
// Results go through a one-word output register, so a new word is taken while
// the last result still waits downstream; emitting stops while that register
// is stalled.
module array_linked_list_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] data_o,
  output logic [3:0]         slot_o,
  output logic               last_o
);
  import alle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  alle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  alle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .slot_o      (slot_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.app_do || cmd.unlink || cmd.rd_step || cmd.emit_full ||
     cmd.emit_miss || cmd.emit_empty) |-> sts.out_free)
    else $error("result written while output register is held");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_i != MODE_UNUSED) |=> in_stall_o)
    else $error("engine not busy after taking a word");
`endif

endmodule

### src/alle_ctrl.sv
// Controller FSM of the array linked list engine.
// Sequences append, delete scans and read walks; uses alle_pkg.
module alle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         mode_i,
  output logic               in_stall_o,
  input  alle_pkg::sts_t     sts_i,
  output alle_pkg::cmd_t     cmd_o
);
  import alle_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_APP    = 10'b0000000010,
    S_LINK   = 10'b0000000100,
    S_SRCH   = 10'b0000001000,
    S_PRED   = 10'b0000010000,
    S_UNLINK = 10'b0000100000,
    S_MISS   = 10'b0001000000,
    S_EMPTY  = 10'b0010000000,
    S_READ   = 10'b0100000000,
    S_FULL   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (mode_i)
            MODE_APPEND: state_d = sts_i.fcount_empty ? S_FULL : S_APP;
            MODE_DELETE: state_d = S_SRCH;
            MODE_READ:   state_d = sts_i.head_null ? S_EMPTY : S_READ;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_full = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_APP: begin
        if (sts_i.out_free) begin
          cmd_o.app_do = 1'b1;
          state_d = sts_i.tail_null ? S_IDLE : S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d = S_IDLE;
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = sts_i.found_any ? S_PRED : S_MISS;
        end
      end
      S_PRED: begin
        cmd_o.pred_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_UNLINK;
        end
      end
      S_UNLINK: begin
        if (sts_i.out_free) begin
          cmd_o.unlink = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_miss = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.rd_step = 1'b1;
          if (sts_i.rd_end) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/alle_dp.sv
// Datapath of the array linked list engine: slot stores, free stack,
// head/tail pointers, scan registers and the output word register; uses alle_pkg.
module alle_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 mode_i,
  input  logic signed [31:0]         value_i,
  input  alle_pkg::cmd_t             cmd_i,
  output alle_pkg::sts_t             sts_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         data_o,
  output logic [3:0]                 slot_o,
  output logic                       last_o
);
  import alle_pkg::*;

  logic [DATA_W-1:0] val_mem [DEPTH];
  logic [PTR_W-1:0]  nxt_mem [DEPTH];
  logic [IDX_W-1:0]  fstk_q  [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [PTR_W-1:0]  head_q, tail_q;
  logic [CNT_W-1:0]  fcount_q;

  logic [DATA_W-1:0] value_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [PTR_W-1:0]  s_q, pred_q, nexts_q;
  logic              found_q;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [DATA_W-1:0] data_q;
  logic [SLOT_W-1:0] slot_q;
  logic              last_q;

  logic [DATA_W-1:0] rd_val;
  logic [PTR_W-1:0]  rd_nxt;
  logic              rd_vld;
  logic              hit;
  logic [CNT_W-1:0]  fcm1;
  logic [IDX_W-1:0]  pop_slot;
  logic              head_is_s;
  logic [PTR_W-1:0]  new_head;
  logic              emit_any;
  logic              rd_end;
  logic              scan_last;

  assign rd_val    = val_mem[idx_q];
  assign rd_nxt    = nxt_mem[idx_q];
  assign rd_vld    = valid_q[idx_q];
  assign hit       = rd_vld && (rd_val == value_q);
  assign fcm1      = fcount_q - CNT_W'(1);
  assign pop_slot  = fstk_q[fcm1[IDX_W-1:0]];
  assign head_is_s = (head_q == s_q);
  assign new_head  = head_is_s ? ((nexts_q < PTR_W'(DEPTH)) ? nexts_q : NULL_PTR) : head_q;
  assign rd_end    = (rd_nxt >= PTR_W'(DEPTH)) || (cnt_q == IDX_W'(DEPTH - 1));
  assign scan_last = (idx_q == IDX_W'(DEPTH - 1));
  assign emit_any  = cmd_i.app_do | cmd_i.unlink | cmd_i.emit_full | cmd_i.emit_miss
                   | cmd_i.emit_empty | cmd_i.rd_step;

  always_comb begin
    sts_o.fcount_empty = (fcount_q == '0) || (fcount_q > CNT_W'(DEPTH));
    sts_o.tail_null    = (tail_q == NULL_PTR);
    sts_o.head_null    = (head_q == NULL_PTR);
    sts_o.scan_last    = scan_last;
    sts_o.found_any    = found_q | hit;
    sts_o.rd_end       = rd_end;
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  // slot stores, undefined until written
  always_ff @(posedge clk_i) begin
    if (cmd_i.app_do) begin
      val_mem[pop_slot] <= value_q;
      nxt_mem[pop_slot] <= NULL_PTR;
    end
    if (cmd_i.link) begin
      nxt_mem[tail_q[IDX_W-1:0]] <= s_q;
    end
    if (cmd_i.unlink && !head_is_s && (pred_q != NULL_PTR)) begin
      nxt_mem[pred_q[IDX_W-1:0]] <= nexts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      head_q      <= NULL_PTR;
      tail_q      <= NULL_PTR;
      fcount_q    <= CNT_W'(DEPTH);
      out_valid_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        fstk_q[i] <= IDX_W'(DEPTH - 1 - i);
      end
    end else begin
      out_valid_q <= emit_any | (out_valid_q & out_stall_i);
      if (cmd_i.app_do) begin
        valid_q[pop_slot] <= 1'b1;
        fcount_q <= fcm1;
        if (tail_q == NULL_PTR) begin
          head_q <= PTR_W'(pop_slot);
          tail_q <= PTR_W'(pop_slot);
        end
      end
      if (cmd_i.link) begin
        tail_q <= s_q;
      end
      if (cmd_i.unlink) begin
        head_q <= new_head;
        if (tail_q == s_q) begin
          tail_q <= (new_head == NULL_PTR) ? NULL_PTR : pred_q;
        end
        valid_q[s_q[IDX_W-1:0]] <= 1'b0;
        if (fcount_q < CNT_W'(DEPTH)) begin
          fstk_q[fcount_q[IDX_W-1:0]] <= s_q[IDX_W-1:0];
          fcount_q <= fcount_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= value_i;
      found_q <= 1'b0;
      pred_q  <= NULL_PTR;
      cnt_q   <= '0;
      idx_q   <= (mode_i == MODE_READ) ? head_q[IDX_W-1:0] : '0;
    end
    if (cmd_i.srch_step) begin
      if (hit) begin
        s_q     <= PTR_W'(idx_q);
        nexts_q <= rd_nxt;
        found_q <= 1'b1;
      end
      idx_q <= scan_last ? '0 : idx_q + IDX_W'(1);
    end
    if (cmd_i.pred_step) begin
      if ((PTR_W'(idx_q) != s_q) && rd_vld && (rd_nxt == s_q)) begin
        pred_q <= PTR_W'(idx_q);
      end
      idx_q <= scan_last ? '0 : idx_q + IDX_W'(1);
    end
    if (cmd_i.app_do) begin
      s_q <= PTR_W'(pop_slot);
    end
    if (cmd_i.rd_step) begin
      idx_q <= rd_nxt[IDX_W-1:0];
      cnt_q <= cnt_q + IDX_W'(1);
    end

    if (cmd_i.app_do) begin
      status_q <= STAT_OK;
      data_q   <= value_q;
      slot_q   <= SLOT_W'(pop_slot);
      last_q   <= 1'b1;
    end else if (cmd_i.unlink) begin
      status_q <= STAT_OK;
      data_q   <= value_q;
      slot_q   <= SLOT_W'(s_q[IDX_W-1:0]);
      last_q   <= 1'b1;
    end else if (cmd_i.emit_full) begin
      status_q <= STAT_FULL;
      data_q   <= value_q;
      slot_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_miss) begin
      status_q <= STAT_NOT_FOUND;
      data_q   <= value_q;
      slot_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_empty) begin
      status_q <= STAT_EMPTY;
      data_q   <= '0;
      slot_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.rd_step) begin
      status_q <= STAT_OK;
      data_q   <= rd_val;
      slot_q   <= SLOT_W'(idx_q);
      last_q   <= rd_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign slot_o      = slot_q;
  assign last_o      = last_q;

endmodule

### verif/tb_top.sv
// Self-checking testbench for array_linked_list_engine_unit: append, delete and read
// words go in, and every result word is checked against a cycle-free list predictor.
// Depends on alle_pkg and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alle_pkg::*;

  localparam int         RAND_WORDS  = 360;
  localparam int         DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]                mode;
    logic signed [DATA_W-1:0]  value;
    bit                        hold;
  } list_cmd_t;

  typedef struct {
    status_e                   status;
    logic signed [DATA_W-1:0]  data;
    logic [SLOT_W-1:0]         slot;
    logic                      last;
  } list_res_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                mode = MODE_APPEND;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic signed [DATA_W-1:0]  data;
  logic [SLOT_W-1:0]         slot;
  logic                      last;

  list_cmd_t  pending_cmds[$];
  list_res_t  expected_results[$];
  logic signed [DATA_W-1:0] gen_vals[$];
  list_cmd_t  word;
  list_res_t  want;
  int         n_taken = 0;
  int         n_total = 0;
  int         n_fail = 0;

  // predicted engine state
  logic signed [DATA_W-1:0] slot_val[DEPTH];
  logic [PTR_W-1:0]         slot_nxt[DEPTH];
  bit                       slot_used[DEPTH];
  logic [IDX_W-1:0]         free_stk[DEPTH];
  int                       free_n;
  logic [PTR_W-1:0]         head_p;
  logic [PTR_W-1:0]         tail_p;

  wire [1:0] idle_phase = (n_total == 0) ? 2'd0 :
                          (3 * n_taken >= 2 * n_total) ? 2'd2 :
                          (3 * n_taken >= n_total) ? 2'd1 : 2'd0;
  wire integer send_idle_pct = (idle_phase == 2'd0) ? 38 : (idle_phase == 2'd1) ? 73 : 0;
  wire integer recv_idle_pct = (idle_phase == 2'd0) ? 73 : (idle_phase == 2'd1) ? 38 : 0;

  array_linked_list_engine_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .data_o      (data),
    .slot_o      (slot),
    .last_o      (last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit slot_live(input int p);
    return p < DEPTH && slot_used[p];
  endfunction

  task automatic predict_list_op(input logic [1:0] m, input logic signed [DATA_W-1:0] v);
    int s;
    int pred;
    int n;
    logic [PTR_W-1:0] x;
    logic [PTR_W-1:0] nx;
    if (m == MODE_APPEND) begin
      if (free_n == 0) begin
        expected_results.push_back('{STAT_FULL, v, '0, 1'b1});
      end else begin
        free_n--;
        s = free_stk[free_n];
        slot_val[s]  = v;
        slot_nxt[s]  = NULL_PTR;
        slot_used[s] = 1'b1;
        if (slot_live(tail_p)) slot_nxt[tail_p] = PTR_W'(s);
        else head_p = PTR_W'(s);
        tail_p = PTR_W'(s);
        expected_results.push_back('{STAT_OK, v, SLOT_W'(s), 1'b1});
      end
    end else if (m == MODE_DELETE) begin
      s = DEPTH;
      pred = DEPTH;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i] && slot_val[i] == v) s = i;
      end
      if (s == DEPTH) begin
        expected_results.push_back('{STAT_NOT_FOUND, v, '0, 1'b1});
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (i != s && slot_used[i] && slot_nxt[i] == s) pred = i;
        end
        if (head_p == s) begin
          head_p = slot_live(slot_nxt[s]) ? slot_nxt[s] : NULL_PTR;
        end else if (pred != DEPTH) begin
          slot_nxt[pred] = slot_nxt[s];
        end
        if (tail_p == s) tail_p = (head_p == NULL_PTR) ? NULL_PTR : PTR_W'(pred);
        slot_used[s] = 1'b0;
        slot_nxt[s]  = NULL_PTR;
        if (free_n < DEPTH) begin
          free_stk[free_n] = IDX_W'(s);
          free_n++;
        end
        expected_results.push_back('{STAT_OK, v, SLOT_W'(s), 1'b1});
      end
    end else if (m == MODE_READ) begin
      x = head_p;
      n = 0;
      if (!slot_live(x)) begin
        expected_results.push_back('{STAT_EMPTY, '0, '0, 1'b1});
      end else begin
        while (slot_live(x) && n < DEPTH) begin
          nx = slot_nxt[x];
          expected_results.push_back('{STAT_OK, slot_val[x], SLOT_W'(x),
                                       !slot_live(nx) || (n + 1) >= DEPTH});
          n++;
          x = nx;
        end
      end
    end
  endtask

  // the generator keeps a multiset of list values to aim deletes at live entries
  task automatic queue_cmd(input logic [1:0] m, input logic signed [DATA_W-1:0] v,
                           input bit hold);
    bit hit;
    pending_cmds.push_back('{m, v, hold});
    hit = 1'b0;
    if (m == MODE_APPEND && gen_vals.size() < DEPTH) gen_vals.push_back(v);
    if (m == MODE_DELETE) begin
      for (int i = 0; i < gen_vals.size() && !hit; i++) begin
        if (gen_vals[i] == v) begin
          gen_vals.delete(i);
          hit = 1'b1;
        end
      end
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 5) return DATA_W'($urandom_range(7));
    if (r == 5) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // driver: prediction happens here at acceptance, before the next word is chosen
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      mode     <= MODE_APPEND;
      value    <= '0;
      n_taken  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_list_op(mode, value);
        n_taken <= n_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 &&
            !(pending_cmds[0].hold && (expected_results.size() != 0 || out_valid)) &&
            $urandom_range(99) >= send_idle_pct) begin
          word = pending_cmds.pop_front();
          in_valid <= 1'b1;
          mode     <= word.mode;
          value    <= word.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall <= 1'b0;
    else out_stall <= $urandom_range(99) < recv_idle_pct;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected word status %0d data %0d slot %0d last %0d",
                 $realtime, status, data, slot, last);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          n_fail++;
          $display("%0t: status expected %0d got %0d", $realtime, want.status, status);
        end
        if (data !== want.data) begin
          n_fail++;
          $display("%0t: data expected %0d got %0d", $realtime, want.data, data);
        end
        if (slot !== want.slot) begin
          n_fail++;
          $display("%0t: slot expected %0d got %0d", $realtime, want.slot, slot);
        end
        if (last !== want.last) begin
          n_fail++;
          $display("%0t: last expected %0d got %0d", $realtime, want.last, last);
        end
      end
    end
  end

  initial begin
    logic signed [DATA_W-1:0] fill_vals[DEPTH];
    int  n_rand;
    int  k;
    int  pick;
    bit  grow;
    logic signed [DATA_W-1:0] v;

    fill_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 7, 1, 7, 2,
                  3, 4, 5, 6, 8, 9, 7, 10};
    for (int i = 0; i < DEPTH; i++) begin
      slot_val[i]  = '0;
      slot_nxt[i]  = NULL_PTR;
      slot_used[i] = 1'b0;
      free_stk[i]  = IDX_W'(DEPTH - 1 - i);
    end
    head_p = NULL_PTR;
    tail_p = NULL_PTR;
    free_n = DEPTH;

    // directed: empty list, miss, unused mode, fill to full, duplicates, ends and middle
    queue_cmd(MODE_READ, 32'sh1234_5678, 1'b0);
    queue_cmd(MODE_DELETE, 5, 1'b0);
    queue_cmd(MODE_UNUSED, -1, 1'b0);
    for (int i = 0; i < DEPTH; i++) queue_cmd(MODE_APPEND, fill_vals[i], 1'b0);
    queue_cmd(MODE_APPEND, 32'sh55aa_55aa, 1'b0);
    queue_cmd(MODE_READ, 0, 1'b0);
    queue_cmd(MODE_DELETE, 7, 1'b0);
    queue_cmd(MODE_DELETE, 32'sh8000_0000, 1'b0);
    queue_cmd(MODE_DELETE, 10, 1'b0);
    queue_cmd(MODE_DELETE, 7, 1'b0);
    queue_cmd(MODE_READ, 0, 1'b1);

    n_rand = 0;
    k = 0;
    grow = 1'b1;
    while (n_rand < RAND_WORDS) begin
      if (k % 30 == 0) grow = $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < 3) begin
        queue_cmd(MODE_UNUSED, $urandom, 1'b0);
      end else begin
        if (pick < 13) begin
          queue_cmd(MODE_READ, $urandom, k == 0 || k == 200);
        end else if (pick < (grow ? 75 : 35)) begin
          queue_cmd(MODE_APPEND, pick_value(), k == 0 || k == 200);
        end else begin
          if (gen_vals.size() != 0 && $urandom_range(9) != 0)
            v = gen_vals[$urandom_range(gen_vals.size() - 1)];
          else
            v = pick_value();
          queue_cmd(MODE_DELETE, v, k == 0 || k == 200);
        end
        n_rand++;
      end
      k++;
    end
    n_total = pending_cmds.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (pending_cmds.size() != 0 || in_valid);
    do @(negedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (n_fail == 0 && expected_results.size() == 0) begin
      $display("array_linked_list_engine_unit regression: pass");
    end else begin
      $display("array_linked_list_engine_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("array_linked_list_engine_unit regression: fail");
    $finish;
  end

endmodule

### files.f
src/alle_pkg.sv
src/alle_ctrl.sv
src/alle_dp.sv
src/array_linked_list_engine_unit.sv
verif/tb_top.sv
